// ----- hdl/asps_pkg.sv -----
package asps_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int SQRT_STAGES = 16;

  // stage numbers, input register is stage 1
  localparam int R_DONE = SQRT_STAGES + 3;
  localparam int C_DONE = CORDIC_ITERATIONS + 5;
  localparam int MERGE = (R_DONE > C_DONE) ? R_DONE : C_DONE;
  localparam int R_PAD = MERGE - R_DONE;
  localparam int C_PAD = MERGE - C_DONE;
  localparam int PIPE_DEPTH = MERGE + 2;

  typedef logic signed [32:0] cvec_t;
  typedef logic signed [31:0] angle_t;

  localparam logic signed [32:0] Q28_PI = 33'sd843314857;
  localparam logic signed [32:0] Q28_HALF_PI = 33'sd421657428;
  localparam logic signed [32:0] Q28_TWO_PI = 33'sd1686629713;
  localparam logic signed [32:0] Q30_GAIN_INV = 33'sd652032874;

  typedef enum logic [2:0] {
    CFG_MODE       = 3'd0,
    CFG_MIN_RADIUS = 3'd1,
    CFG_MAX_RADIUS = 3'd2,
    CFG_MIN_THETA  = 3'd3,
    CFG_MAX_THETA  = 3'd4,
    CFG_CENTER_X   = 3'd5,
    CFG_CENTER_Y   = 3'd6
  } cfg_idx_t;

  // atan(2^-i) in q28 radians
  function automatic angle_t atan_q28(input int unsigned i);
    angle_t a;
    case (i)
      0:  a = 32'sd210828714;
      1:  a = 32'sd124459457;
      2:  a = 32'sd65760959;
      3:  a = 32'sd33381290;
      4:  a = 32'sd16755422;
      5:  a = 32'sd8385879;
      6:  a = 32'sd4193963;
      7:  a = 32'sd2097109;
      8:  a = 32'sd1048571;
      9:  a = 32'sd524287;
      10: a = 32'sd262144;
      11: a = 32'sd131072;
      12: a = 32'sd65536;
      13: a = 32'sd32768;
      14: a = 32'sd16384;
      15: a = 32'sd8192;
      16: a = 32'sd4096;
      17: a = 32'sd2048;
      18: a = 32'sd1024;
      19: a = 32'sd512;
      20: a = 32'sd256;
      21: a = 32'sd128;
      22: a = 32'sd64;
      23: a = 32'sd32;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/annulus_sector_point_sampler.sv -----
// Annulus sector point sampler: each input transfer carries three uniform Q0.16 draws and
// yields exactly one output transfer holding a point (Q10.8) on the configured annulus
// sector, either spread over its surface (square-root radius) or on its inner or outer arc.
// The block is a fixed pipeline that takes one item per cycle while the output is not held;
// its depth PIPE_DEPTH is set by the longer of the 16-stage square root plus radius
// scaling and the angle prep plus one CORDIC stage per iteration. When the output
// transfer waits, the whole pipeline holds and in_tready drops until it is taken.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready, and must
// only change while no items are in flight.
module annulus_sector_point_sampler (
  input  logic        clk,
  input  logic        rst_n,
  // input transfer: u_radius [15:0], u_angle [31:16], u_edge [47:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // result transfer: point_x [17:0], point_y [35:18], zero fill [39:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import asps_pkg::*;

  // configuration registers
  logic               mode_r;
  logic [15:0]        rmin_r, rmax_r;
  logic signed [15:0] tmin_r, tmax_r, cx_r, cy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      rmin_r <= 16'd0;
      rmax_r <= 16'd256;
      tmin_r <= 16'sd0;
      tmax_r <= 16'sd25736;
      cx_r   <= 16'sd0;
      cy_r   <= 16'sd0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:       mode_r <= cfg_data[0];
        CFG_MIN_RADIUS: rmin_r <= cfg_data;
        CFG_MAX_RADIUS: rmax_r <= cfg_data;
        CFG_MIN_THETA:  tmin_r <= cfg_data;
        CFG_MAX_THETA:  tmax_r <= cfg_data;
        CFG_CENTER_X:   cx_r   <= cfg_data;
        CFG_CENTER_Y:   cy_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: everything advances together
  logic [PIPE_DEPTH-1:0] vld_r;
  logic en;

  assign en = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // stage 1: input register
  logic [15:0] u1_r, u2_r, u3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r <= in_tdata[15:0];
      u2_r <= in_tdata[31:16];
      u3_r <= in_tdata[47:32];
    end
  end

  // stage 2: angle span product, inner arc test
  logic [16:0]        esum;
  logic [32:0]        eprod;
  logic               inner;
  logic [16:0]        edge_sr;
  logic signed [16:0] tspan;
  logic signed [33:0] aprod_r;

  assign esum  = {1'b0, rmin_r} + {1'b0, rmax_r};
  assign eprod = {17'd0, u3_r} * {16'd0, esum};
  assign inner = eprod < {1'b0, rmin_r, 16'd0};
  assign tspan = {tmax_r[15], tmax_r} - {tmin_r[15], tmin_r};

  always_ff @(posedge clk) begin
    if (en) begin
      edge_sr <= {edge_sr[15:0], inner};
      aprod_r <= $signed({1'b0, u2_r}) * tspan;
    end
  end

  // stage 3: angle in q3.12
  logic signed [15:0] t_r;
  logic signed [17:0] t_sum;

  assign t_sum = {{2{tmin_r[15]}}, tmin_r} + 18'(aprod_r >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_sum[15:0];
    end
  end

  // stage 4: q28 angle, wrap into [-pi, pi) then fold into [-pi/2, pi/2]
  logic signed [32:0] zw, zwrap, zfold;
  logic               fold;
  angle_t             z_r;
  logic               neg_r;

  always_comb begin
    zw = {t_r[15], t_r, 16'd0};
    if (zw >= Q28_PI) begin
      zwrap = zw - Q28_TWO_PI;
    end else if (zw < -Q28_PI) begin
      zwrap = zw + Q28_TWO_PI;
    end else begin
      zwrap = zw;
    end
    fold = 1'b1;
    if (zwrap > Q28_HALF_PI) begin
      zfold = zwrap - Q28_PI;
    end else if (zwrap < -Q28_HALF_PI) begin
      zfold = zwrap + Q28_PI;
    end else begin
      zfold = zwrap;
      fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r   <= zfold[31:0];
      neg_r <= fold;
    end
  end

  // stages 5 .. C_DONE: cos and sin
  logic signed [31:0] cos_c, sin_c;

  asps_cordic u_cordic (
    .clk     (clk),
    .en      (en),
    .z_in    (z_r),
    .neg_in  (neg_r),
    .cos_out (cos_c),
    .sin_out (sin_c)
  );

  // stages 2 .. 17: square root of the radius draw
  logic [15:0] root;

  asps_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .u_in (u1_r),
    .root (root)
  );

  // stage 18: radius span product; stage 19: radius
  logic signed [16:0] rspan;
  logic signed [33:0] rprod_r;
  logic signed [17:0] r_sum;
  logic [15:0]        r_r;

  assign rspan = {1'b0, rmax_r} - {1'b0, rmin_r};
  assign r_sum = {2'b0, rmin_r} + 18'(rprod_r >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      rprod_r <= $signed({1'b0, root}) * rspan;
      if (mode_r) begin
        r_r <= edge_sr[16] ? rmin_r : rmax_r;
      end else begin
        r_r <= r_sum[15:0];
      end
    end
  end

  // align the radius and the trig results
  logic [15:0]        r_m;
  logic signed [31:0] cos_m, sin_m;

  if (R_PAD == 0) begin : g_rnopad
    assign r_m = r_r;
  end else begin : g_rpad
    logic [15:0] rd_r [R_PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        rd_r[0] <= r_r;
        for (int k = 1; k < R_PAD; k++) begin
          rd_r[k] <= rd_r[k-1];
        end
      end
    end
    assign r_m = rd_r[R_PAD-1];
  end

  if (C_PAD == 0) begin : g_cnopad
    assign cos_m = cos_c;
    assign sin_m = sin_c;
  end else begin : g_cpad
    logic signed [31:0] cd_r [C_PAD];
    logic signed [31:0] sd_r [C_PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        cd_r[0] <= cos_c;
        sd_r[0] <= sin_c;
        for (int k = 1; k < C_PAD; k++) begin
          cd_r[k] <= cd_r[k-1];
          sd_r[k] <= sd_r[k-1];
        end
      end
    end
    assign cos_m = cd_r[C_PAD-1];
    assign sin_m = sd_r[C_PAD-1];
  end

  // stage MERGE+1: radius times cos and sin (q8.8 times q30)
  logic signed [48:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= $signed({1'b0, r_m}) * cos_m;
      py_r <= $signed({1'b0, r_m}) * sin_m;
    end
  end

  // round to q8.8, add center, clamp to [-98304, 98303] in the 18 bit field
  function automatic logic [17:0] place(input logic signed [15:0] ctr,
                                        input logic signed [48:0] p);
    logic signed [48:0] pr;
    logic signed [18:0] sh;
    logic signed [19:0] v;
    logic [17:0] res;
    pr = p + 49'sd536870912;
    sh = 19'(pr >>> 30);
    v = {{4{ctr[15]}}, ctr} + {sh[18], sh};
    if (v < -20'sd98304) begin
      res = 18'h28000;
    end else if (v > 20'sd98303) begin
      res = 18'h17fff;
    end else begin
      res = v[17:0];
    end
    return res;
  endfunction

  // stage MERGE+2: output register
  logic [17:0] ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= place(cx_r, px_r);
      oy_r <= place(cy_r, py_r);
    end
  end

  assign out_tdata = {4'd0, oy_r, ox_r};

endmodule

// ----- hdl/asps_sqrt.sv -----
module asps_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] u_in,
  output logic [15:0] root
);
  import asps_pkg::*;

  logic [31:0] rem_r [SQRT_STAGES];
  logic [31:0] res_r [SQRT_STAGES];

  // one digit per stage, bit weight 2^(30-2k)
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [32:0] BIT = 33'd1 << (30 - 2 * k);
    logic [31:0] rem_in, res_in;
    logic [32:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = {u_in, 16'd0};
      assign res_in = 32'd0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = {1'b0, res_in} + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k] <= 32'({1'b0, rem_in} - trial);
          res_r[k] <= 32'({2'b0, res_in[31:1]} + BIT);
        end else begin
          rem_r[k] <= rem_in;
          res_r[k] <= {1'b0, res_in[31:1]};
        end
      end
    end
  end

  assign root = res_r[SQRT_STAGES-1][15:0];

endmodule

// ----- hdl/asps_cordic.sv -----
module asps_cordic (
  input  logic                  clk,
  input  logic                  en,
  input  asps_pkg::angle_t      z_in,
  input  logic                  neg_in,
  output logic signed [31:0]    cos_out,
  output logic signed [31:0]    sin_out
);
  import asps_pkg::*;

  cvec_t  x_r [CORDIC_ITERATIONS];
  cvec_t  y_r [CORDIC_ITERATIONS];
  angle_t z_r [CORDIC_ITERATIONS];
  logic   neg_r [CORDIC_ITERATIONS];
  logic signed [31:0] cos_r, sin_r;

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
    localparam angle_t ATAN = atan_q28(i);
    cvec_t  x_in, y_in, xs, ys;
    angle_t z_in_i;
    logic   neg_in_i;

    if (i == 0) begin : g_first
      assign x_in = Q30_GAIN_INV;
      assign y_in = '0;
      assign z_in_i = z_in;
      assign neg_in_i = neg_in;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in_i = z_r[i-1];
      assign neg_in_i = neg_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= neg_in_i;
        if (!z_in_i[31]) begin
          x_r[i] <= x_in - ys;
          y_r[i] <= y_in + xs;
          z_r[i] <= z_in_i - ATAN;
        end else begin
          x_r[i] <= x_in + ys;
          y_r[i] <= y_in - xs;
          z_r[i] <= z_in_i + ATAN;
        end
      end
    end
  end

  // undo the half turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[CORDIC_ITERATIONS-1]) begin
        cos_r <= 32'(-x_r[CORDIC_ITERATIONS-1]);
        sin_r <= 32'(-y_r[CORDIC_ITERATIONS-1]);
      end else begin
        cos_r <= 32'(x_r[CORDIC_ITERATIONS-1]);
        sin_r <= 32'(y_r[CORDIC_ITERATIONS-1]);
      end
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

// ----- verif/tb_annulus_sector_point_sampler.sv -----
module tb_annulus_sector_point_sampler;
  import asps_pkg::*;

  // one sampled point
  typedef struct packed {
    logic signed [17:0] py;
    logic signed [17:0] px;
  } point_t;

  // one row of the directed table; has_fixed marks a hand-worked expectation
  typedef struct {
    logic [15:0] u_r;
    logic [15:0] u_a;
    logic [15:0] u_e;
    bit          has_fixed;
    point_t      fixed_pt;
  } draw_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  annulus_sector_point_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow copy of the configuration registers
  logic        sh_mode;
  logic [15:0] sh_rmin;
  logic [15:0] sh_rmax;
  logic [15:0] sh_tmin;
  logic [15:0] sh_tmax;
  logic [15:0] sh_cx;
  logic [15:0] sh_cy;

  point_t expected_points[$];
  int     err_count;
  int     points_seen;
  int     items_sent;
  bit     calm;        // no random idling while set
  bit     hold_out;    // receiver holds off while set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout at %0t", $time);
    $display("simulation failed");
    $finish;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_of(longint n);
    longint res;
    longint bt;
    res = 0;
    bt = 64'd1 << 30;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // clamp one coordinate to [-98304, 98303] in the 18-bit field
  function automatic logic signed [17:0] coord_of(longint ctr, longint r, longint trig);
    longint v;
    v = ctr + floor_sh(r * trig + (64'sd1 << 29), 30);
    if (v < -98304) v = -98304;
    if (v > 98303) v = 98303;
    return v[17:0];
  endfunction

  // point for one draw under the current shadow configuration
  function automatic point_t sample_point(logic [15:0] ur, logic [15:0] ua, logic [15:0] ue);
    longint rmin, rmax, tmin, tmax, r, t, z, x, y, xs, ys, c, s;
    bit     flip;
    point_t p;
    rmin = sh_rmin;
    rmax = sh_rmax;
    tmin = $signed(sh_tmin);
    tmax = $signed(sh_tmax);
    if (sh_mode)
      r = (longint'(ue) * (rmin + rmax) < rmin * 65536) ? rmin : rmax;
    else
      r = rmin + floor_sh(root_of(longint'(ur) << 16) * (rmax - rmin), 16);
    t = tmin + floor_sh(longint'(ua) * (tmax - tmin), 16);
    z = t * 65536;
    while (z >= longint'(Q28_PI)) z = z - longint'(Q28_TWO_PI);
    while (z < -longint'(Q28_PI)) z = z + longint'(Q28_TWO_PI);
    flip = 1'b0;
    if (z > longint'(Q28_HALF_PI)) begin
      z = z - longint'(Q28_PI);
      flip = 1'b1;
    end else if (z < -longint'(Q28_HALF_PI)) begin
      z = z + longint'(Q28_PI);
      flip = 1'b1;
    end
    x = longint'(Q30_GAIN_INV);
    y = 0;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_q28(i));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_q28(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    p.px = coord_of(longint'($signed(sh_cx)), r, c);
    p.py = coord_of(longint'($signed(sh_cy)), r, s);
    return p;
  endfunction

  // cfg_valid stays high across a burst; apply_setting drops it at the end
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_MODE:       sh_mode = val[0];
      CFG_MIN_RADIUS: sh_rmin = val;
      CFG_MAX_RADIUS: sh_rmax = val;
      CFG_MIN_THETA:  sh_tmin = val;
      CFG_MAX_THETA:  sh_tmax = val;
      CFG_CENTER_X:   sh_cx = val;
      CFG_CENTER_Y:   sh_cy = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic md, logic [15:0] rmn, logic [15:0] rmx,
                               logic [15:0] tmn, logic [15:0] tmx,
                               logic [15:0] cx, logic [15:0] cy);
    write_reg(CFG_MODE, {15'd0, md});
    write_reg(CFG_MIN_RADIUS, rmn);
    write_reg(CFG_MAX_RADIUS, rmx);
    write_reg(CFG_MIN_THETA, tmn);
    write_reg(CFG_MAX_THETA, tmx);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    cfg_valid <= 1'b0;
  endtask

  // offer one draw; the expectation is queued at the accepting edge
  // in_tvalid stays high between back to back draws, drain drops it
  task automatic send_draw(logic [15:0] ur, logic [15:0] ua, logic [15:0] ue);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ue, ua, ur};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_points.push_back(sample_point(ur, ua, ue));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH + 5) @(negedge clk);
  endtask

  function automatic logic [15:0] pick16;
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // receiver side: random stalls, plus the long hold-off when asked
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out)
        out_tready <= 1'b0;
      else
        out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // result checker
  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[35:0];
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d", $time, got.px, got.py);
        err_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.px !== want.px) begin
          $display("%0t: point_x expected %0d got %0d", $time, want.px, got.px);
          err_count++;
        end
        if (got.py !== want.py) begin
          $display("%0t: point_y expected %0d got %0d", $time, want.py, got.py);
          err_count++;
        end
        if (out_tdata[39:36] !== 4'd0) begin
          $display("%0t: fill bits expected 0 got %h", $time, out_tdata[39:36]);
          err_count++;
        end
      end
    end
  end

  draw_row_t dir_rows[$];

  function automatic draw_row_t row(logic [15:0] ur, logic [15:0] ua, logic [15:0] ue,
                                    bit fx = 0, int ex = 0, int ey = 0);
    draw_row_t d;
    d.u_r = ur;
    d.u_a = ua;
    d.u_e = ue;
    d.has_fixed = fx;
    d.fixed_pt.px = 18'(ex);
    d.fixed_pt.py = 18'(ey);
    return d;
  endfunction

  initial begin
    point_t pr;
    int     n_rand;
    err_count = 0;
    points_seen = 0;
    items_sent = 0;
    calm = 1'b0;
    hold_out = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    // reset values of the registers
    sh_mode = 1'b0;
    sh_rmin = 16'd0;
    sh_rmax = 16'd256;
    sh_tmin = 16'd0;
    sh_tmax = 16'd25736;
    sh_cx = 16'd0;
    sh_cy = 16'd0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under the reset setting: unit radius, angle 0 to 2pi
    dir_rows.push_back(row(16'h0000, 16'h0000, 16'h0000, 1, 0, 0));    // zero radius
    dir_rows.push_back(row(16'hFFFF, 16'h0000, 16'h0000, 1, 255, 0));  // full radius, angle 0
    dir_rows.push_back(row(16'hFFFF, 16'h8000, 16'hFFFF));
    dir_rows.push_back(row(16'hFFFF, 16'hFFFF, 16'h1234));
    dir_rows.push_back(row(16'h4000, 16'h4000, 16'h0000));
    dir_rows.push_back(row(16'h0001, 16'h2000, 16'hFFFF));
    foreach (dir_rows[k]) begin
      pr = sample_point(dir_rows[k].u_r, dir_rows[k].u_a, dir_rows[k].u_e);
      if (dir_rows[k].has_fixed && pr !== dir_rows[k].fixed_pt) begin
        $display("%0t: table row %0d expected %0d,%0d predicted %0d,%0d", $time, k,
                 dir_rows[k].fixed_pt.px, dir_rows[k].fixed_pt.py, pr.px, pr.py);
        err_count++;
      end
      send_draw(dir_rows[k].u_r, dir_rows[k].u_a, dir_rows[k].u_e);
    end
    drain();

    // edge mode, extremes: zero radii sum, reversed angles, clamped coordinates
    apply_setting(1'b1, 16'd0, 16'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_draw(16'hFFFF, 16'h0000, 16'h0000);
    send_draw(16'h0000, 16'hFFFF, 16'hFFFF);
    drain();
    apply_setting(1'b1, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_draw(16'h0000, 16'h0000, 16'h0000);
    send_draw(16'h0000, 16'h8000, 16'hFFFF);
    send_draw(16'h0000, 16'hFFFF, 16'h7FFF);
    drain();
    // inner versus outer arc right at the threshold
    apply_setting(1'b1, 16'd256, 16'd768, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_draw(16'h0000, 16'h1234, 16'h3FFF);  // inner, zero angle span
    send_draw(16'h0000, 16'h1234, 16'h4000);  // outer
    drain();
    // reversed radii in surface mode, far negative center
    apply_setting(1'b0, 16'hFFFF, 16'd0, 16'sd6434, 16'sh8000, 16'sh8000, 16'sh8000);
    send_draw(16'hFFFF, 16'hFFFF, 16'h0000);
    send_draw(16'h8000, 16'h0000, 16'hFFFF);
    send_draw(16'h0000, 16'h5555, 16'hAAAA);
    drain();

    // random phases, each under its own random setting
    n_rand = 0;
    for (int ph = 0; ph < 9; ph++) begin
      apply_setting(1'($urandom_range(1)), pick16(), pick16(), pick16(), pick16(),
                    pick16(), pick16());
      calm = (ph == 3);
      if (ph == 5) begin
        // long receiver hold-off while the sender keeps going
        fork
          begin
            hold_out = 1'b1;
            repeat (200) @(negedge clk);
            hold_out = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 150; k++) begin
        send_draw(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)));
        n_rand++;
      end
      calm = 1'b0;
      drain();
    end

    $display("covered %0d draws (%0d random) over surface and edge modes,", items_sent,
             n_rand);
    $display("extreme and reversed settings, %0d points checked", points_seen);
    if (err_count == 0 && expected_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d points missing", err_count, expected_points.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
